// ===== hw/rtl/dq_pkg.sv =====
package dq_pkg;

  localparam int unsigned FUNC_BITS     = 3;
  localparam int unsigned OUT_WORD_BITS = 32;
  localparam int unsigned COUNT_BITS    = 11;

  typedef enum logic [FUNC_BITS-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_LOOK       = 3'd4
  } func_t;

  // what one row of cells does in a cycle
  typedef enum logic [1:0] {
    CH_HOLD,
    CH_PUSH,
    CH_POP,
    CH_APPEND
  } chain_op_t;

  typedef struct packed {
    logic [FUNC_BITS-1:0]            func;
    logic signed [OUT_WORD_BITS-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [OUT_WORD_BITS-1:0] popped_word;
    logic                            popped_valid;
    logic                            op_error;
    logic [COUNT_BITS-1:0]           entry_count;
    logic                            is_empty;
    logic signed [OUT_WORD_BITS-1:0] front_word;
    logic signed [OUT_WORD_BITS-1:0] back_word;
  } out_t;

endpackage

// ===== hw/rtl/dq_cell.sv =====
module dq_cell import dq_pkg::*; #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk,
  input  chain_op_t            op,
  input  logic                 hit,
  input  logic [WORD_BITS-1:0] left_data,
  input  logic [WORD_BITS-1:0] right_data,
  input  logic [WORD_BITS-1:0] push_data,
  output logic [WORD_BITS-1:0] data
);

  logic [WORD_BITS-1:0] data_r;
  logic [WORD_BITS-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (op)
      CH_HOLD:   data_nxt = data_r;
      CH_PUSH:   data_nxt = left_data;
      CH_POP:    data_nxt = right_data;
      CH_APPEND: if (hit) data_nxt = push_data;
      default:   data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== hw/rtl/dq_chain.sv =====
module dq_chain import dq_pkg::*; #(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned CW        = 11
) (
  input  logic                 clk,
  input  chain_op_t            op,
  input  logic [CW-1:0]        wr_idx,
  input  logic [WORD_BITS-1:0] push_data,
  output logic [WORD_BITS-1:0] first_word,
  output logic [WORD_BITS-1:0] second_word
);

  logic [WORD_BITS-1:0] cell_data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_d;
    logic [WORD_BITS-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = push_data;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
    end

    // last cell keeps its word on a pop, the slot falls outside the count anyway
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end

    dq_cell #(
      .WORD_BITS(WORD_BITS)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .hit       (wr_idx == CW'(i)),
      .left_data (left_d),
      .right_data(right_d),
      .push_data (push_data),
      .data      (cell_data[i])
    );
  end

  assign first_word  = cell_data[0];
  assign second_word = cell_data[1];

endmodule

// ===== hw/rtl/double_ended_queue_top.sv =====
// Bounded double-ended queue of DEPTH words. The words are kept twice, in two rows of
// cells: one row holds them in order from the front, the other in order from the back,
// so the front and back words always sit in the first cell of a row and every command
// only shifts a row by one cell or writes the cell that the count selects. One
// command is taken per clock cycle and its result appears in the output register on
// the next cycle; the block stalls only while reset is held or that register holds a
// result that has not been taken. Pops on an empty queue and pushes on a full one change
// nothing and set op_error; codes above look only behave as look only. Storage is
// 2 x DEPTH x WORD_BITS flip-flops; cells beyond the count hold stale words that are
// never shown.
module double_ended_queue_top import dq_pkg::*; #(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic                 out_valid_r;
  out_t                 out_r;

  logic                 accept;
  logic                 full;
  logic                 empty;
  logic [WORD_BITS-1:0] value_w;
  chain_op_t            a_op;
  chain_op_t            b_op;
  logic [WORD_BITS-1:0] a_first;
  logic [WORD_BITS-1:0] a_second;
  logic [WORD_BITS-1:0] b_first;
  logic [WORD_BITS-1:0] b_second;
  logic [WORD_BITS-1:0] popped_w;
  logic [WORD_BITS-1:0] front_w;
  logic [WORD_BITS-1:0] back_w;
  logic                 pvalid;
  logic                 err;

  logic [OUT_WORD_BITS-1:0] popped_o;
  logic [OUT_WORD_BITS-1:0] front_o;
  logic [OUT_WORD_BITS-1:0] back_o;
  logic [COUNT_BITS-1:0]    count_o;

  // nothing is taken while reset is held
  assign in_ready = rst_n && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);

  if (WORD_BITS <= OUT_WORD_BITS) begin : g_narrow
    assign value_w  = in_data.value[WORD_BITS-1:0];
    if (WORD_BITS == OUT_WORD_BITS) begin : g_same
      assign popped_o = popped_w;
      assign front_o  = front_w;
      assign back_o   = back_w;
    end else begin : g_sext
      assign popped_o = {{(OUT_WORD_BITS-WORD_BITS){popped_w[WORD_BITS-1]}}, popped_w};
      assign front_o  = {{(OUT_WORD_BITS-WORD_BITS){front_w[WORD_BITS-1]}}, front_w};
      assign back_o   = {{(OUT_WORD_BITS-WORD_BITS){back_w[WORD_BITS-1]}}, back_w};
    end
  end else begin : g_wide
    assign value_w  = {{(WORD_BITS-OUT_WORD_BITS){1'b0}}, in_data.value};
    assign popped_o = popped_w[OUT_WORD_BITS-1:0];
    assign front_o  = front_w[OUT_WORD_BITS-1:0];
    assign back_o   = back_w[OUT_WORD_BITS-1:0];
  end

  if (CW >= COUNT_BITS) begin : g_cnt_trunc
    assign count_o = count_nxt[COUNT_BITS-1:0];
  end else begin : g_cnt_ext
    assign count_o = {{(COUNT_BITS-CW){1'b0}}, count_nxt};
  end

  // row a: index 0 is the front; row b: index 0 is the back
  always_comb begin
    a_op      = CH_HOLD;
    b_op      = CH_HOLD;
    count_nxt = count_r;
    pvalid    = 1'b0;
    err       = 1'b0;
    popped_w  = '0;
    front_w   = a_first;
    back_w    = b_first;
    if (accept) begin
      unique case (in_data.func)
        FN_PUSH_FRONT: begin
          if (full) begin
            err = 1'b1;
          end else begin
            a_op      = CH_PUSH;
            b_op      = CH_APPEND;
            count_nxt = count_r + CW'(1);
            front_w   = value_w;
            if (empty) back_w = value_w;
          end
        end
        FN_PUSH_BACK: begin
          if (full) begin
            err = 1'b1;
          end else begin
            a_op      = CH_APPEND;
            b_op      = CH_PUSH;
            count_nxt = count_r + CW'(1);
            back_w    = value_w;
            if (empty) front_w = value_w;
          end
        end
        FN_POP_FRONT: begin
          if (empty) begin
            err = 1'b1;
          end else begin
            a_op      = CH_POP;
            count_nxt = count_r - CW'(1);
            pvalid    = 1'b1;
            popped_w  = a_first;
            front_w   = a_second;
          end
        end
        FN_POP_BACK: begin
          if (empty) begin
            err = 1'b1;
          end else begin
            b_op      = CH_POP;
            count_nxt = count_r - CW'(1);
            pvalid    = 1'b1;
            popped_w  = b_first;
            back_w    = b_second;
          end
        end
        FN_LOOK: ;
        default: ;
      endcase
    end
  end

  dq_chain #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS),
    .CW       (CW)
  ) u_front_row (
    .clk        (clk),
    .op         (a_op),
    .wr_idx     (count_r),
    .push_data  (value_w),
    .first_word (a_first),
    .second_word(a_second)
  );

  dq_chain #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS),
    .CW       (CW)
  ) u_back_row (
    .clk        (clk),
    .op         (b_op),
    .wr_idx     (count_r),
    .push_data  (value_w),
    .first_word (b_first),
    .second_word(b_second)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      out_r.popped_word  <= popped_o;
      out_r.popped_valid <= pvalid;
      out_r.op_error     <= err;
      out_r.entry_count  <= count_o;
      out_r.is_empty     <= (count_nxt == '0);
      out_r.front_word   <= (count_nxt == '0) ? '0 : front_o;
      out_r.back_word    <= (count_nxt == '0) ? '0 : back_o;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("stored count above depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted transaction gave no result");

  a_pop_empty_error: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && empty && (in_data.func == FN_POP_FRONT || in_data.func == FN_POP_BACK))
    |=> (out_r.op_error && !out_r.popped_valid))
    else $error("pop on empty queue not flagged");

  a_count_moves_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r))
    else $error("count changed without a transaction");

endmodule
